>>> rtl/assert_macros.svh
// Assertion macros for the RTL; included by mams_ctrl.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/mams_pkg.sv
package mams_pkg;

    localparam int SLOT_ADDR_W = 6;

    typedef enum logic [1:0] {
        OP_CHECK  = 2'd0,
        OP_SNOOZE = 2'd1,
        OP_STOP   = 2'd2,
        OP_LOAD   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_ONCE     = 2'd0,
        MODE_DAILY    = 2'd1,
        MODE_WEEKDAYS = 2'd2,
        MODE_WEEKENDS = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        slot_enable;
        t_mode       repeat_mode;
        logic [2:0]  slot;
        logic [31:0] now_ms;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [2:0]  weekday;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
    } t_in_item;

    localparam int IN_ITEM_W  = $bits(t_in_item);
    localparam int IN_TDATA_W = ((IN_ITEM_W + 7) / 8) * 8;

    typedef struct packed {
        logic       stop_sound;
        logic       start_sound;
        logic [2:0] active_slot;
        logic       active_valid;
        logic       snoozed;
        logic       ringing;
    } t_result;

    localparam int OUT_TDATA_W = $bits(t_result);

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        t_mode       mode;
        logic        enabled;
        logic [13:0] last_year;
        logic [3:0]  last_month;
        logic [4:0]  last_day;
    } t_slot;

    typedef struct packed {
        logic                   en;
        logic [SLOT_ADDR_W-1:0] addr;
        t_slot                  data;
    } t_wr_req;

endpackage

>>> rtl/mams_table.sv
module mams_table #(
    parameter int NUM_SLOTS = 8,
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [SLOT_W-1:0]    i_rd_addr,
    output mams_pkg::t_slot      o_rd_data,
    input  mams_pkg::t_wr_req    i_wr
);

    mams_pkg::t_slot        r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   r_vld;
    mams_pkg::t_slot        r_q;
    logic                   r_q_vld;
    logic [SLOT_W-1:0]      wr_idx;

    assign wr_idx = i_wr.addr[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[wr_idx] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_q     <= r_mem[i_rd_addr];
            r_q_vld <= r_vld[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[wr_idx] <= 1'b1;
        end
    end

    // An entry never written since reset reads as a disabled slot with a zero date.
    assign o_rd_data = r_q_vld ? r_q : '0;

endmodule

>>> rtl/mams_ctrl.sv
`include "assert_macros.svh"

module mams_ctrl #(
    parameter int NUM_SLOTS = 8,
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [21:0]          i_snooze_len,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mams_pkg::t_op        i_op,
    input  mams_pkg::t_in_item   i_item,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output mams_pkg::t_result    o_res,
    output logic                 o_rd_en,
    output logic [SLOT_W-1:0]    o_rd_addr,
    input  mams_pkg::t_slot      i_rd_data,
    output mams_pkg::t_wr_req    o_wr
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    mams_pkg::t_state   r_state, n_state;
    mams_pkg::t_op      r_op, n_op;
    mams_pkg::t_in_item r_item, n_item;
    logic               r_ring, n_ring;
    logic               r_snooze, n_snooze;
    logic               r_act_vld, n_act_vld;
    logic [SLOT_W-1:0]  r_act_idx, n_act_idx;
    logic [31:0]        r_deadline, n_deadline;
    logic               r_start, n_start;
    logic               r_stop, n_stop;
    logic [SLOT_W-1:0]  r_rd_addr, n_rd_addr;
    logic               r_rd_done, n_rd_done;
    logic               r_q_pend, n_q_pend;
    logic [SLOT_W-1:0]  r_q_idx, n_q_idx;
    logic               r_q_last, n_q_last;
    mams_pkg::t_slot    ent;
    logic               hit;
    logic [7:0]         act_ext;

    function automatic logic day_allowed(mams_pkg::t_mode mode, logic [2:0] wd);
        logic ok;
        case (mode)
            mams_pkg::MODE_WEEKDAYS: ok = (wd >= 3'd1) && (wd <= 3'd5);
            mams_pkg::MODE_WEEKENDS: ok = (wd == 3'd0) || (wd == 3'd6);
            default:                 ok = 1'b1;
        endcase
        return ok;
    endfunction

    assign ent = i_rd_data;
    assign hit = ent.enabled
              && (ent.hour == r_item.hour)
              && (ent.minute == r_item.minute)
              && (r_item.second == 6'd0)
              && day_allowed(ent.mode, r_item.weekday)
              && !((ent.last_year == r_item.year)
                   && (ent.last_month == r_item.month)
                   && (ent.last_day == r_item.day));

    assign act_ext = 8'(r_act_idx);

    always_comb begin
        o_res.ringing      = r_ring;
        o_res.snoozed      = r_snooze;
        o_res.active_valid = r_act_vld;
        o_res.active_slot  = r_act_vld ? act_ext[2:0] : 3'd0;
        o_res.start_sound  = r_start;
        o_res.stop_sound   = r_stop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mams_pkg::S_IDLE;
            r_ring     <= 1'b0;
            r_snooze   <= 1'b0;
            r_act_vld  <= 1'b0;
            r_act_idx  <= '0;
            r_deadline <= '0;
            r_start    <= 1'b0;
            r_stop     <= 1'b0;
            r_rd_done  <= 1'b1;
            r_q_pend   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ring     <= n_ring;
            r_snooze   <= n_snooze;
            r_act_vld  <= n_act_vld;
            r_act_idx  <= n_act_idx;
            r_deadline <= n_deadline;
            r_start    <= n_start;
            r_stop     <= n_stop;
            r_rd_done  <= n_rd_done;
            r_q_pend   <= n_q_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_item    <= n_item;
        r_rd_addr <= n_rd_addr;
        r_q_idx   <= n_q_idx;
        r_q_last  <= n_q_last;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_item      = r_item;
        n_ring      = r_ring;
        n_snooze    = r_snooze;
        n_act_vld   = r_act_vld;
        n_act_idx   = r_act_idx;
        n_deadline  = r_deadline;
        n_start     = r_start;
        n_stop      = r_stop;
        n_rd_addr   = r_rd_addr;
        n_rd_done   = r_rd_done;
        n_q_pend    = 1'b0;
        n_q_idx     = r_q_idx;
        n_q_last    = r_q_last;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_rd_addr;
        o_wr        = '0;

        case (r_state)
            mams_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op    = i_op;
                    n_item  = i_item;
                    n_start = 1'b0;
                    n_stop  = 1'b0;
                    n_state = mams_pkg::S_EXEC;
                end
            end
            mams_pkg::S_EXEC: begin
                n_state = mams_pkg::S_DONE;
                case (r_op)
                    mams_pkg::OP_CHECK: begin
                        if (r_snooze && (r_item.now_ms >= r_deadline)) begin
                            n_ring   = 1'b1;
                            n_snooze = 1'b0;
                            n_start  = 1'b1;
                        end else if (!r_ring) begin
                            n_state   = mams_pkg::S_SCAN;
                            n_rd_addr = '0;
                            n_rd_done = 1'b0;
                        end
                    end
                    mams_pkg::OP_SNOOZE: begin
                        if (r_ring) begin
                            n_ring     = 1'b0;
                            n_snooze   = 1'b1;
                            n_deadline = r_item.now_ms + 32'(i_snooze_len);
                            n_stop     = 1'b1;
                        end
                    end
                    mams_pkg::OP_STOP: begin
                        if (r_ring || r_snooze) begin
                            n_ring    = 1'b0;
                            n_snooze  = 1'b0;
                            n_act_vld = 1'b0;
                            n_act_idx = '0;
                            n_stop    = 1'b1;
                        end
                    end
                    mams_pkg::OP_LOAD: begin
                        if (7'(r_item.slot) < 7'(NUM_SLOTS)) begin
                            o_wr.en              = 1'b1;
                            o_wr.addr            = mams_pkg::SLOT_ADDR_W'(r_item.slot);
                            o_wr.data.hour       = r_item.hour;
                            o_wr.data.minute     = r_item.minute;
                            o_wr.data.mode       = r_item.repeat_mode;
                            o_wr.data.enabled    = r_item.slot_enable;
                            o_wr.data.last_year  = '0;
                            o_wr.data.last_month = '0;
                            o_wr.data.last_day   = '0;
                        end
                    end
                    default: n_state = mams_pkg::S_DONE;
                endcase
            end
            mams_pkg::S_SCAN: begin
                if (!r_rd_done) begin
                    o_rd_en   = 1'b1;
                    n_q_pend  = 1'b1;
                    n_q_idx   = r_rd_addr;
                    n_q_last  = (r_rd_addr == LAST_SLOT);
                    n_rd_addr = r_rd_addr + 1'b1;
                    n_rd_done = (r_rd_addr == LAST_SLOT);
                end
                if (r_q_pend && hit) begin
                    // The lowest matching slot fires and the scan ends here.
                    n_act_idx            = r_q_idx;
                    n_act_vld            = 1'b1;
                    n_ring               = 1'b1;
                    n_start              = 1'b1;
                    o_wr.en              = 1'b1;
                    o_wr.addr            = mams_pkg::SLOT_ADDR_W'(r_q_idx);
                    o_wr.data            = ent;
                    o_wr.data.enabled    = ent.mode != mams_pkg::MODE_ONCE;
                    o_wr.data.last_year  = r_item.year;
                    o_wr.data.last_month = r_item.month;
                    o_wr.data.last_day   = r_item.day;
                    n_rd_done            = 1'b1;
                    n_q_pend             = 1'b0;
                    n_state              = mams_pkg::S_DONE;
                end else if (r_q_pend && r_q_last) begin
                    n_state = mams_pkg::S_DONE;
                end
            end
            mams_pkg::S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = mams_pkg::S_IDLE;
                end
            end
            default: n_state = mams_pkg::S_IDLE;
        endcase
    end

    `ASSERT_CLK(a_start_rings, i_clk, i_rst_n, r_start |-> r_ring,
        "Sound start flagged while the alarm is not ringing.")
    `ASSERT_CLK(a_alarm_has_slot, i_clk, i_rst_n, (r_ring || r_snooze) |-> r_act_vld,
        "Alarm ringing or snoozed without an active slot.")
    `ASSERT_CLK(a_write_state, i_clk, i_rst_n,
        o_wr.en |-> (r_state == mams_pkg::S_EXEC || r_state == mams_pkg::S_SCAN),
        "Slot table written outside of execution.")
    `ASSERT_NEVER(a_start_and_stop, i_clk, i_rst_n, r_start && r_stop,
        "Sound start and stop flagged for the same request.")

endmodule

>>> rtl/multi_alarm_matcher_snooze.sv
// Alarm matcher with snooze. Each request carries an operation in s_axis_tuser (check time,
// snooze, stop or load slot) and time, date and slot fields in s_axis_tdata; every request
// returns one status result on m_axis. Snooze, stop, load and a check that ends a snooze go
// from the execute state straight to the done state; a check that scans the slot table first
// runs a scan state, reading the synchronous table memory one slot per cycle and stopping at
// the first slot that fires. The snooze length register resets to 300000 ms; the user must
// write it through i_cfg_we and i_cfg_wdata only while no request is in flight (not enforced).
module multi_alarm_matcher_snooze #(
    parameter int NUM_SLOTS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [21:0]                         i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: hour, minute, second, weekday, year, month, day, now_ms, slot,
    // repeat_mode, slot_enable, zero padding.
    input  logic [mams_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Fields from bit 0: op.
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: ringing, snoozed, active_valid, active_slot, start_sound, stop_sound.
    output logic [mams_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [21:0]         r_snooze_len;
    logic                r_out_valid;
    mams_pkg::t_result   r_out_data;
    mams_pkg::t_in_item  in_item;
    mams_pkg::t_op       in_op;
    mams_pkg::t_result   res;
    logic                res_valid;
    logic                res_ready;
    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    mams_pkg::t_slot     rd_data;
    mams_pkg::t_wr_req   wr;

    assign in_item = mams_pkg::t_in_item'(s_axis_tdata[mams_pkg::IN_ITEM_W-1:0]);
    assign in_op   = mams_pkg::t_op'(s_axis_tuser);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snooze_len <= 22'd300000;
        end else if (i_cfg_we) begin
            r_snooze_len <= i_cfg_wdata;
        end
    end

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_data <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    mams_ctrl #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snooze_len (r_snooze_len),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_op         (in_op),
        .i_item       (in_item),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_wr         (wr)
    );

    mams_table #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr      (wr)
    );

endmodule

>>> bench/multi_alarm_matcher_snooze_tb.sv
module multi_alarm_matcher_snooze_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS   = 8;
    localparam int RAND_ITEMS  = 360;
    localparam int NUM_PHASES  = 5;
    localparam int SETTLE_CYC  = 20;
    localparam int LONG_HOLD   = 300;
    localparam mams_pkg::t_result RES_IDLE = '0;

    typedef struct {
        mams_pkg::t_op      op;
        mams_pkg::t_in_item item;
        bit                 has_exp;
    } t_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [21:0]                     i_cfg_wdata = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [mams_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic [1:0]                      s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [mams_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // Typed expectation for directed rows; travels alongside the request.
    logic              row_has_exp = 1'b0;
    mams_pkg::t_result row_exp = '0;

    // Predictor state.
    mams_pkg::t_slot alarm_tab [NUM_SLOTS];
    logic        ring_on;
    logic        snooze_on;
    logic        act_on;
    logic [2:0]  act_idx;
    logic [31:0] wake_ms;
    logic [31:0] snooze_len;

    mams_pkg::t_result status_q [$];
    int sent_cnt = 0;
    int rcv_cnt = 0;
    int err_cnt = 0;
    int start_cnt = 0;
    int stop_cnt = 0;
    bit no_idle = 1'b0;
    bit hold_req = 1'b0;

    logic [31:0] cur_ms;
    logic [4:0]  pool_h [4];
    logic [5:0]  pool_m [4];

    mams_pkg::t_in_item cap_item;
    mams_pkg::t_result  cap_pred;
    mams_pkg::t_result  got_res;
    mams_pkg::t_result  want_res;

    multi_alarm_matcher_snooze #(
        .NUM_SLOTS(NUM_SLOTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #20ms;
        $display("Timeout at %0t", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic bit day_ok(mams_pkg::t_mode md, logic [2:0] wd);
        case (md)
            mams_pkg::MODE_WEEKDAYS: return (wd >= 3'd1) && (wd <= 3'd5);
            mams_pkg::MODE_WEEKENDS: return (wd == 3'd0) || (wd == 3'd6);
            default:                 return 1'b1;
        endcase
    endfunction

    task automatic reset_alarm_state();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            alarm_tab[i] = '0;
        end
        ring_on    = 1'b0;
        snooze_on  = 1'b0;
        act_on     = 1'b0;
        act_idx    = '0;
        wake_ms    = '0;
        snooze_len = 32'd300000;
    endtask

    task automatic predict_status(input mams_pkg::t_op op, input mams_pkg::t_in_item it,
                                  output mams_pkg::t_result r);
        logic start_p;
        logic stop_p;
        bit   found;
        start_p = 1'b0;
        stop_p  = 1'b0;
        found   = 1'b0;
        case (op)
            mams_pkg::OP_CHECK: begin
                if (snooze_on && it.now_ms >= wake_ms) begin
                    ring_on   = 1'b1;
                    snooze_on = 1'b0;
                    start_p   = 1'b1;
                end else if (!ring_on) begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (!found && alarm_tab[i].enabled &&
                            alarm_tab[i].hour == it.hour && alarm_tab[i].minute == it.minute &&
                            it.second == 6'd0 && day_ok(alarm_tab[i].mode, it.weekday) &&
                            !(alarm_tab[i].last_year == it.year &&
                              alarm_tab[i].last_month == it.month &&
                              alarm_tab[i].last_day == it.day)) begin
                            found   = 1'b1;
                            act_idx = i[2:0];
                            act_on  = 1'b1;
                            ring_on = 1'b1;
                            start_p = 1'b1;
                            alarm_tab[i].last_year  = it.year;
                            alarm_tab[i].last_month = it.month;
                            alarm_tab[i].last_day   = it.day;
                            if (alarm_tab[i].mode == mams_pkg::MODE_ONCE) begin
                                alarm_tab[i].enabled = 1'b0;
                            end
                        end
                    end
                end
            end
            mams_pkg::OP_SNOOZE: begin
                if (ring_on) begin
                    ring_on   = 1'b0;
                    snooze_on = 1'b1;
                    wake_ms   = it.now_ms + snooze_len;
                    stop_p    = 1'b1;
                end
            end
            mams_pkg::OP_STOP: begin
                if (ring_on || snooze_on) begin
                    ring_on   = 1'b0;
                    snooze_on = 1'b0;
                    act_on    = 1'b0;
                    act_idx   = '0;
                    stop_p    = 1'b1;
                end
            end
            default: begin
                if (int'(it.slot) < NUM_SLOTS) begin
                    alarm_tab[it.slot].hour       = it.hour;
                    alarm_tab[it.slot].minute     = it.minute;
                    alarm_tab[it.slot].mode       = it.repeat_mode;
                    alarm_tab[it.slot].enabled    = it.slot_enable;
                    alarm_tab[it.slot].last_year  = '0;
                    alarm_tab[it.slot].last_month = '0;
                    alarm_tab[it.slot].last_day   = '0;
                end
            end
        endcase
        r.ringing      = ring_on;
        r.snoozed      = snooze_on;
        r.active_valid = act_on;
        r.active_slot  = act_on ? act_idx : 3'd0;
        r.start_sound  = start_p;
        r.stop_sound   = stop_p;
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                cap_item = s_axis_tdata[mams_pkg::IN_ITEM_W-1:0];
                predict_status(mams_pkg::t_op'(s_axis_tuser), cap_item, cap_pred);
                status_q.push_back(row_has_exp ? row_exp : cap_pred);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got_res = m_axis_tdata;
                rcv_cnt++;
                if (got_res.start_sound) start_cnt++;
                if (got_res.stop_sound) stop_cnt++;
                if (status_q.size() == 0) begin
                    $display("%0t: result %0h with no request outstanding", $time, got_res);
                    err_cnt++;
                end else begin
                    want_res = status_q.pop_front();
                    check_field("ringing", 32'(want_res.ringing), 32'(got_res.ringing));
                    check_field("snoozed", 32'(want_res.snoozed), 32'(got_res.snoozed));
                    check_field("active_valid", 32'(want_res.active_valid),
                                32'(got_res.active_valid));
                    check_field("active_slot", 32'(want_res.active_slot),
                                32'(got_res.active_slot));
                    check_field("start_sound", 32'(want_res.start_sound),
                                32'(got_res.start_sound));
                    check_field("stop_sound", 32'(want_res.stop_sound),
                                32'(got_res.stop_sound));
                end
            end
        end
    end

    initial begin
        int gap;
        wait (i_rst_n);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 9);
            if (hold_req) begin
                hold_req = 1'b0;
                gap = LONG_HOLD;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    task automatic send_request(input mams_pkg::t_op op, input mams_pkg::t_in_item it,
                                input bit has_exp);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(mams_pkg::IN_TDATA_W - mams_pkg::IN_ITEM_W){1'b0}}, it};
        s_axis_tuser  <= op;
        row_has_exp   <= has_exp;
        row_exp       <= RES_IDLE;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        sent_cnt++;
    endtask

    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        wait (rcv_cnt == sent_cnt);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_snooze_len(input logic [21:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        snooze_len = {10'd0, v};
        @(posedge i_clk);
    endtask

    function automatic t_row row(mams_pkg::t_op op, int h, int mi, int s, int wd, int y, int mo,
                                 int d, logic [31:0] ms, int sl, mams_pkg::t_mode md, int en,
                                 int hx);
        t_row r;
        r.op                = op;
        r.item              = '0;
        r.item.hour         = 5'(h);
        r.item.minute       = 6'(mi);
        r.item.second       = 6'(s);
        r.item.weekday      = 3'(wd);
        r.item.year         = 14'(y);
        r.item.month        = 4'(mo);
        r.item.day          = 5'(d);
        r.item.now_ms       = ms;
        r.item.slot         = 3'(sl);
        r.item.repeat_mode  = md;
        r.item.slot_enable  = (en != 0);
        r.has_exp           = (hx != 0);
        return r;
    endfunction

    task automatic make_random(output mams_pkg::t_op op, output mams_pkg::t_in_item it);
        int          sel;
        int          k;
        logic [95:0] raw;
        sel = $urandom_range(0, 99);
        k   = $urandom_range(0, 3);
        raw = {$urandom, $urandom, $urandom};
        it  = raw[mams_pkg::IN_ITEM_W-1:0];
        if (sel < 5) begin
            op = mams_pkg::t_op'($urandom_range(0, 3));
        end else if (sel < 17) begin
            op = mams_pkg::OP_LOAD;
            if ($urandom_range(0, 7) == 0) begin
                it.hour   = 5'($urandom_range(0, 31));
                it.minute = 6'($urandom_range(0, 63));
            end else begin
                it.hour   = pool_h[k];
                it.minute = pool_m[k];
            end
            it.repeat_mode = mams_pkg::t_mode'($urandom_range(0, 3));
            it.slot_enable = ($urandom_range(0, 4) != 0);
        end else if (sel < 27) begin
            op = mams_pkg::OP_SNOOZE;
            it.now_ms = cur_ms;
        end else if (sel < 35) begin
            op = mams_pkg::OP_STOP;
        end else begin
            op = mams_pkg::OP_CHECK;
            cur_ms = cur_ms + $urandom_range(0, 3000);
            if (snooze_on && $urandom_range(0, 3) == 0) begin
                cur_ms = wake_ms + $urandom_range(0, 2) - 1;
            end
            it.now_ms = cur_ms;
            if ($urandom_range(0, 9) < 6) begin
                it.hour   = pool_h[k];
                it.minute = pool_m[k];
                it.second = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 59)) : 6'd0;
            end else begin
                it.hour   = 5'($urandom_range(0, 23));
                it.minute = 6'($urandom_range(0, 59));
                it.second = 6'($urandom_range(0, 59));
            end
            it.weekday = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 19) == 0) begin
                it.year  = '0;
                it.month = '0;
                it.day   = '0;
            end else begin
                it.year  = $urandom_range(0, 1) ? 14'd2024 : 14'd9999;
                it.month = 4'($urandom_range(1, 2));
                it.day   = 5'($urandom_range(1, 3));
            end
        end
    endtask

    initial begin
        t_row               dir_tab [$];
        mams_pkg::t_op      op;
        mams_pkg::t_in_item it;
        logic [21:0]        len_tab [NUM_PHASES];

        reset_alarm_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir_tab.push_back(row(mams_pkg::OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                              mams_pkg::MODE_ONCE, 0, 1));
        dir_tab.push_back(row(mams_pkg::OP_SNOOZE, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                              mams_pkg::MODE_ONCE, 0, 1));
        dir_tab.push_back(row(mams_pkg::OP_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                              mams_pkg::MODE_ONCE, 0, 1));
        dir_tab.push_back(row(mams_pkg::OP_LOAD, 23, 59, 0, 0, 0, 0, 0, 0, 7,
                              mams_pkg::MODE_WEEKENDS, 1, 1));
        dir_tab.push_back(row(mams_pkg::OP_LOAD, 6, 30, 0, 0, 0, 0, 0, 0, 0,
                              mams_pkg::MODE_DAILY, 1, 1));
        dir_tab.push_back(row(mams_pkg::OP_LOAD, 6, 30, 0, 0, 0, 0, 0, 0, 1,
                              mams_pkg::MODE_ONCE, 1, 1));
        dir_tab.push_back(row(mams_pkg::OP_LOAD, 31, 63, 0, 0, 0, 0, 0, 0, 3,
                              mams_pkg::MODE_DAILY, 1, 1));
        dir_tab.push_back(row(mams_pkg::OP_LOAD, 7, 0, 0, 0, 0, 0, 0, 0, 2,
                              mams_pkg::MODE_WEEKDAYS, 1, 1));
        // A check dated 0-0-0 looks as if every slot had already fired today.
        dir_tab.push_back(row(mams_pkg::OP_CHECK, 6, 30, 0, 1, 0, 0, 0, 100, 0,
                              mams_pkg::MODE_ONCE, 0, 1));
        dir_tab.push_back(row(mams_pkg::OP_CHECK, 6, 30, 5, 1, 2024, 1, 1, 500, 0,
                              mams_pkg::MODE_ONCE, 0, 1));
        dir_tab.push_back(row(mams_pkg::OP_CHECK, 6, 30, 0, 1, 2024, 1, 1, 1000, 0,
                              mams_pkg::MODE_ONCE, 0, 0));
        dir_tab.push_back(row(mams_pkg::OP_SNOOZE, 0, 0, 0, 0, 0, 0, 0, 3000, 0,
                              mams_pkg::MODE_ONCE, 0, 0));
        // While snoozed, a second slot at the same minute can still fire.
        dir_tab.push_back(row(mams_pkg::OP_CHECK, 6, 30, 0, 1, 2024, 1, 1, 4000, 0,
                              mams_pkg::MODE_ONCE, 0, 0));
        dir_tab.push_back(row(mams_pkg::OP_SNOOZE, 0, 0, 0, 0, 0, 0, 0, 5000, 0,
                              mams_pkg::MODE_ONCE, 0, 0));
        dir_tab.push_back(row(mams_pkg::OP_CHECK, 6, 31, 0, 1, 2024, 1, 1, 304999, 0,
                              mams_pkg::MODE_ONCE, 0, 0));
        dir_tab.push_back(row(mams_pkg::OP_CHECK, 6, 31, 0, 1, 2024, 1, 1, 305000, 0,
                              mams_pkg::MODE_ONCE, 0, 0));
        dir_tab.push_back(row(mams_pkg::OP_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                              mams_pkg::MODE_ONCE, 0, 0));
        dir_tab.push_back(row(mams_pkg::OP_CHECK, 7, 0, 0, 0, 2024, 1, 7, 6000, 0,
                              mams_pkg::MODE_ONCE, 0, 0));
        dir_tab.push_back(row(mams_pkg::OP_CHECK, 23, 59, 0, 6, 2024, 1, 6, 7000, 0,
                              mams_pkg::MODE_ONCE, 0, 0));
        dir_tab.push_back(row(mams_pkg::OP_LOAD, 23, 59, 0, 0, 0, 0, 0, 0, 7,
                              mams_pkg::MODE_WEEKENDS, 0, 0));
        // The deadline wraps past the top of the counter and expires at once.
        dir_tab.push_back(row(mams_pkg::OP_SNOOZE, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0,
                              mams_pkg::MODE_ONCE, 0, 0));
        dir_tab.push_back(row(mams_pkg::OP_CHECK, 31, 63, 0, 7, 16383, 15, 31, 32'hFFFF_FFFF, 0,
                              mams_pkg::MODE_ONCE, 0, 0));
        dir_tab.push_back(row(mams_pkg::OP_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                              mams_pkg::MODE_ONCE, 0, 0));
        dir_tab.push_back(row(mams_pkg::OP_CHECK, 31, 63, 0, 7, 16383, 15, 31, 9000, 0,
                              mams_pkg::MODE_ONCE, 0, 0));
        dir_tab.push_back(row(mams_pkg::OP_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                              mams_pkg::MODE_ONCE, 0, 0));
        dir_tab.push_back(row(mams_pkg::OP_CHECK, 31, 63, 63, 7, 16383, 15, 31, 32'hFFFF_FFFF, 7,
                              mams_pkg::MODE_WEEKENDS, 1, 1));

        foreach (dir_tab[i]) begin
            send_request(dir_tab[i].op, dir_tab[i].item, dir_tab[i].has_exp);
        end
        drain_block();

        len_tab[0] = 22'd1000;
        len_tab[1] = 22'd3600000;
        len_tab[2] = 22'd0;
        len_tab[3] = 22'h3F_FFFF;
        len_tab[4] = 22'($urandom_range(1000, 3600000));

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_snooze_len(len_tab[p]);
            cur_ms = (p == 3) ? 32'hFFF0_0000 : $urandom;
            pool_h[0] = 5'd0;
            pool_m[0] = 6'd0;
            pool_h[3] = 5'd23;
            pool_m[3] = 6'd59;
            for (int k = 1; k < 3; k++) begin
                pool_h[k] = 5'($urandom_range(0, 23));
                pool_m[k] = 6'($urandom_range(0, 59));
            end
            if (p == 1) hold_req = 1'b1;
            for (int n = 0; n < RAND_ITEMS; n++) begin
                if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
                if (p == 2 && n == RAND_ITEMS / 2) drain_block();
                make_random(op, it);
                send_request(op, it, 1'b0);
            end
            no_idle = 1'b0;
            drain_block();
        end

        if (status_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, status_q.size());
            err_cnt++;
        end
        $display("Run covered %0d requests over six snooze lengths, including 0 and the maximum.",
                 sent_cnt);
        $display("Observed %0d sound starts and %0d sound stops; %0d mismatches.",
                 start_cnt, stop_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/mams_pkg.sv
rtl/mams_table.sv
rtl/mams_ctrl.sv
rtl/multi_alarm_matcher_snooze.sv
bench/multi_alarm_matcher_snooze_tb.sv
